FILE: hw/rtl/two_tap_modulated_delay_line_core_defines.svh
// Assertion macros shared by the delay line RTL.
`ifndef TWO_TAP_MODULATED_DELAY_LINE_CORE_DEFINES_SVH
`define TWO_TAP_MODULATED_DELAY_LINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define TMDL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tmdl check failed");
// checked on every clock edge, reset included
`define TMDL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tmdl check failed");
`else
`define TMDL_ASSERT(lbl, prop)
`define TMDL_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: hw/rtl/tmdl_pkg.sv
`timescale 1ns / 1ps

package tmdl_pkg;

  // fixed field widths
  localparam int MOD_BITS     = 28;
  localparam int DLY_BITS     = 12;
  localparam int CFG_IDX_BITS = 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DELAY_A = 1'b0,
    REG_DELAY_B = 1'b1
  } cfg_reg_t;

  // per-read "entry was written since reset" flags
  typedef struct packed {
    logic a0;
    logic a1;
    logic b0;
    logic b1;
  } tap_ok_t;

  // pipeline load strobes for the interpolation stages
  typedef struct packed {
    logic ld2;
    logic ld3;
  } pipe_ctl_t;

endpackage

FILE: hw/rtl/two_tap_modulated_delay_line_core.sv
`timescale 1ns / 1ps
`include "two_tap_modulated_delay_line_core_defines.svh"
// Channel   Dir  Handshake            Payload
// in_       in   in_tvalid/in_tready  sample_in, mod_offset
// out_      out  out_tvalid/out_tready out_a, out_b
// cfg_      in   cfg_wr_en            cfg_index, cfg_wdata
//
// One word per cycle sustained while out_tready is high; an accepted word moves through v1_r, v2_r, v3_r (out_tvalid).
// The rate is set by the sample store: each tap has its own copy with two
// read ports and one shared write, so all four reads and the write fit in
// the accept cycle. DEPTH must be a power of two.
// Reset (rst_n, synchronous) clears control only; store entries not yet
// written since reset read as zero through the fill tracking, with no sweep.
// A stalled output holds stage three and any full stage behind it; empty earlier stages keep filling.

module two_tap_modulated_delay_line_core #(
  parameter int DEPTH       = 4096,
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  // sample_in [SAMPLE_BITS-1:0], mod_offset [+28], zero pad to bytes
  input  logic [((SAMPLE_BITS+tmdl_pkg::MOD_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                                               in_tvalid,
  output logic                                               in_tready,
  // out_a [SAMPLE_BITS-1:0], out_b [+SAMPLE_BITS], zero pad to bytes
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]                  out_tdata,
  output logic                                               out_tvalid,
  input  logic                                               out_tready,
  input  logic                                               cfg_wr_en,
  input  logic [tmdl_pkg::CFG_IDX_BITS-1:0]                  cfg_index,
  input  logic [tmdl_pkg::DLY_BITS-1:0]                      cfg_wdata
);

  import tmdl_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int OUT_W = ((2*SAMPLE_BITS+7)/8)*8;

  logic                          accept;
  logic                          en1;
  logic                          en2;
  logic                          en3;
  logic                          v1_r;
  logic                          v2_r;
  logic                          v3_r;
  pipe_ctl_t                     ctl;
  logic [SAMPLE_BITS-1:0]        sample_in;
  logic signed [MOD_BITS-1:0]    mod_offset;
  logic [AW-1:0]                 wp_r;
  logic [AW-1:0]                 addr_a0;
  logic [AW-1:0]                 addr_a1;
  logic [AW-1:0]                 addr_b0;
  logic [AW-1:0]                 addr_b1;
  tap_ok_t                       ok_r;
  logic [FRAC_BITS-1:0]          frac_r;
  logic [SAMPLE_BITS-1:0]        ra0_r;
  logic [SAMPLE_BITS-1:0]        ra1_r;
  logic [SAMPLE_BITS-1:0]        rb0_r;
  logic [SAMPLE_BITS-1:0]        rb1_r;
  logic signed [SAMPLE_BITS-1:0] out_a;
  logic signed [SAMPLE_BITS-1:0] out_b;

  // unpack input word
  assign sample_in  = in_tdata[SAMPLE_BITS-1:0];
  assign mod_offset = $signed(in_tdata[SAMPLE_BITS +: MOD_BITS]);

  // per-stage advance: a stage loads when its slot is empty or moving on
  always_comb begin
    en3       = !v3_r || out_tready;
    en2       = !v2_r || en3;
    en1       = !v1_r || en2;
    in_tready = en1;
    accept    = in_tvalid && en1;
    ctl.ld2   = en2 && v1_r;
    ctl.ld3   = en3 && v2_r;
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= accept;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  tmdl_addr #(
    .DEPTH     (DEPTH),
    .FRAC_BITS (FRAC_BITS),
    .AW        (AW)
  ) u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .mod_offset (mod_offset),
    .wp_r       (wp_r),
    .addr_a0    (addr_a0),
    .addr_a1    (addr_a1),
    .addr_b0    (addr_b0),
    .addr_b1    (addr_b1),
    .ok_r       (ok_r),
    .frac_r     (frac_r)
  );

  // sample store, one copy per tap
  tmdl_store #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .AW          (AW)
  ) u_store_a (
    .clk      (clk),
    .we       (accept),
    .waddr    (wp_r),
    .wdata    (sample_in),
    .re       (accept),
    .raddr0   (addr_a0),
    .raddr1   (addr_a1),
    .rdata0_r (ra0_r),
    .rdata1_r (ra1_r)
  );

  tmdl_store #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .AW          (AW)
  ) u_store_b (
    .clk      (clk),
    .we       (accept),
    .waddr    (wp_r),
    .wdata    (sample_in),
    .re       (accept),
    .raddr0   (addr_b0),
    .raddr1   (addr_b1),
    .rdata0_r (rb0_r),
    .rdata1_r (rb1_r)
  );

  // interpolation per tap
  tmdl_interp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_interp_a (
    .clk    (clk),
    .ctl    (ctl),
    .rdata0 (ra0_r),
    .rdata1 (ra1_r),
    .ok0    (ok_r.a0),
    .ok1    (ok_r.a1),
    .frac   (frac_r),
    .out_r  (out_a)
  );

  tmdl_interp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_interp_b (
    .clk    (clk),
    .ctl    (ctl),
    .rdata0 (rb0_r),
    .rdata1 (rb1_r),
    .ok0    (ok_r.b0),
    .ok1    (ok_r.b1),
    .frac   (frac_r),
    .out_r  (out_b)
  );

  // output word
  assign out_tdata  = OUT_W'({out_b, out_a});
  assign out_tvalid = v3_r;

  `TMDL_ASSERT(a_accept_fills_s1, (rst_n && accept) |=> v1_r)
  `TMDL_ASSERT_ALWAYS(a_ready_when_s1_empty, !v1_r |-> in_tready)
  `TMDL_ASSERT(a_s2_kept_on_stall, (rst_n && v2_r && v3_r && !out_tready) |=> (v2_r && v3_r))
  `TMDL_ASSERT(a_ld3_only_valid, ctl.ld3 |-> v2_r)

endmodule

FILE: hw/rtl/tmdl_store.sv
`timescale 1ns / 1ps

module tmdl_store #(
  parameter int DEPTH       = 4096,
  parameter int SAMPLE_BITS = 24,
  parameter int AW          = 12
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [SAMPLE_BITS-1:0] wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr0,
  input  logic [AW-1:0]          raddr1,
  output logic [SAMPLE_BITS-1:0] rdata0_r,
  output logic [SAMPLE_BITS-1:0] rdata1_r
);

  logic [SAMPLE_BITS-1:0] store_r [DEPTH];

  // one write port; same-address read returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0_r <= store_r[raddr0];
      rdata1_r <= store_r[raddr1];
    end
  end

endmodule

FILE: hw/rtl/tmdl_addr.sv
`timescale 1ns / 1ps
`include "two_tap_modulated_delay_line_core_defines.svh"

module tmdl_addr #(
  parameter int DEPTH     = 4096,
  parameter int FRAC_BITS = 16,
  parameter int AW        = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [tmdl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tmdl_pkg::DLY_BITS-1:0]        cfg_wdata,
  input  logic                                 accept,
  input  logic signed [tmdl_pkg::MOD_BITS-1:0] mod_offset,
  output logic [AW-1:0]                        wp_r,
  output logic [AW-1:0]                        addr_a0,
  output logic [AW-1:0]                        addr_a1,
  output logic [AW-1:0]                        addr_b0,
  output logic [AW-1:0]                        addr_b1,
  output tmdl_pkg::tap_ok_t                    ok_r,
  output logic [FRAC_BITS-1:0]                 frac_r
);

  import tmdl_pkg::*;

  localparam int CW = (AW > DLY_BITS) ? AW : DLY_BITS;

  logic [AW-1:0]          delay_a_r;
  logic [AW-1:0]          delay_b_r;
  logic [AW-1:0]          wp_nxt;
  logic                   full_r;
  logic [CW-1:0]          dly_ext;
  logic [AW-1:0]          dly_clamped;
  logic [MOD_BITS-2:0]    mod_pos;
  logic [AW-1:0]          ip;
  logic [FRAC_BITS-1:0]   frac;
  tap_ok_t                ok_nxt;

  // clamp a written delay to 1..DEPTH-1
  always_comb begin
    dly_ext = CW'(cfg_wdata);
    if (dly_ext > CW'(DEPTH - 1)) begin
      dly_ext = CW'(DEPTH - 1);
    end
    if (dly_ext == '0) begin
      dly_ext = CW'(1);
    end
    dly_clamped = AW'(dly_ext);
  end

  // delay registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_a_r <= AW'(1);
      delay_b_r <= AW'(1);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELAY_A: delay_a_r <= dly_clamped;
        REG_DELAY_B: delay_b_r <= dly_clamped;
        default: ;
      endcase
    end
  end

  // negative offset reads as zero; integer part wraps by the depth
  always_comb begin
    mod_pos = mod_offset[MOD_BITS-1] ? '0 : mod_offset[MOD_BITS-2:0];
    ip      = AW'(mod_pos[MOD_BITS-2:FRAC_BITS]);
    frac    = mod_pos[FRAC_BITS-1:0];
  end

  // tap addresses: newer sample and the one before it
  always_comb begin
    addr_a0 = wp_r - delay_a_r - ip;
    addr_a1 = addr_a0 - AW'(1);
    addr_b0 = wp_r - delay_b_r - ip;
    addr_b1 = addr_b0 - AW'(1);
  end

  // an entry holds data once the write pointer has passed it
  always_comb begin
    ok_nxt.a0 = full_r || (addr_a0 < wp_r);
    ok_nxt.a1 = full_r || (addr_a1 < wp_r);
    ok_nxt.b0 = full_r || (addr_b0 < wp_r);
    ok_nxt.b1 = full_r || (addr_b1 < wp_r);
    wp_nxt    = wp_r + AW'(1);
  end

  // write pointer and fill flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      full_r <= 1'b0;
    end else if (accept) begin
      wp_r <= wp_nxt;
      if (wp_r == AW'(DEPTH - 1)) begin
        full_r <= 1'b1;
      end
    end
  end

  // side data that travels with the memory read
  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r   <= ok_nxt;
      frac_r <= frac;
    end
  end

  `TMDL_ASSERT(a_wp_hold, (rst_n && !accept) |=> (wp_r == $past(wp_r)))
  `TMDL_ASSERT(a_wp_step, (rst_n && accept) |=> (wp_r == AW'($past(wp_r) + AW'(1))))
  `TMDL_ASSERT(a_full_sticky, (rst_n && full_r) |=> full_r)
  `TMDL_ASSERT(a_delay_nonzero, (delay_a_r != '0) && (delay_b_r != '0))

endmodule

FILE: hw/rtl/tmdl_interp.sv
`timescale 1ns / 1ps

module tmdl_interp #(
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  tmdl_pkg::pipe_ctl_t           ctl,
  input  logic [SAMPLE_BITS-1:0]        rdata0,
  input  logic [SAMPLE_BITS-1:0]        rdata1,
  input  logic                          ok0,
  input  logic                          ok1,
  input  logic [FRAC_BITS-1:0]          frac,
  output logic signed [SAMPLE_BITS-1:0] out_r
);

  import tmdl_pkg::*;

  localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;

  logic signed [SAMPLE_BITS-1:0] r0;
  logic signed [SAMPLE_BITS-1:0] r1;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     fs;
  logic signed [PW-1:0]          prod;
  logic signed [PW-1:0]          prod_r;
  logic signed [SAMPLE_BITS-1:0] base_r;

  // unwritten entries read as zero
  // r0*(1-f) + r1*f = r0 + (r1-r0)*f
  always_comb begin
    r0   = ok0 ? $signed(rdata0) : '0;
    r1   = ok1 ? $signed(rdata1) : '0;
    diff = $signed({r1[SAMPLE_BITS-1], r1}) - $signed({r0[SAMPLE_BITS-1], r0});
    fs   = $signed({1'b0, frac});
    prod = diff * fs;
  end

  // product stage
  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      prod_r <= prod;
      base_r <= r0;
    end
  end

  // floor shift of the product, then add the base sample
  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      out_r <= base_r + $signed(prod_r[FRAC_BITS +: SAMPLE_BITS]);
    end
  end

endmodule
